/* hdl/led_ring_ripple_fader_core_macros.svh */
// Assertion macros shared by the ripple fader RTL.
`ifndef LED_RING_RIPPLE_FADER_CORE_MACROS_SVH
`define LED_RING_RIPPLE_FADER_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define LRRF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ripple fader check failed");

// Check a consequent in the cycle after its antecedent.
`define LRRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ripple fader check failed");

`endif

/* hdl/lrrf_pkg.sv */
// Shared types and constants of the LED ring ripple fader.
package lrrf_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 8;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_IDX_LIMIT = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_STEP  = 4'd1;

  localparam logic [7:0] LIMIT_RESET = 8'd150;
  localparam logic [3:0] STEP_RESET  = 4'd3;

  // Fade settings handed to the frame sequencer
  typedef struct packed {
    logic [7:0] limit;
    logic [3:0] step;
  } lrrf_cfg_t;

endpackage

/* hdl/led_ring_ripple_fader_core.sv */
// Top level of the LED ring ripple fader: config registers, level store and sequencer.
//
//   channel | direction | handshake         | word
//   --------+-----------+-------------------+-------------------------------------
//   in      | input     | in_valid/stall    | frame_tick
//   out     | output    | out_valid/stall   | led_index, blue_level, last_led
//   cfg     | input     | cfg_valid/ready   | cfg_index, cfg_data
//
// A frame serializes the ramp pass, the seed probes, four seed writes on a hit and a
// readout per LED through one store port.
// A word with frame_tick low is taken and dropped.
// Reset is asynchronous, active low, then a clearing pass zeroes the store.
// Output stalls hold the current LED word; no new frame is taken until the last LED goes out.
module led_ring_ripple_fader_core #(
  parameter int unsigned RING_SIZE    = 18,
  parameter int unsigned SPREAD_REACH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         frame_tick_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [4:0]                   led_index_o,
  output logic [7:0]                   blue_level_o,
  output logic                         last_led_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lrrf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lrrf_pkg::CfgDataW-1:0] cfg_data_i
);
  import lrrf_pkg::*;
  `include "led_ring_ripple_fader_core_macros.svh"

  localparam int unsigned IW = $clog2(RING_SIZE);

  lrrf_cfg_t     cfg_q;
  logic          busy;
  logic          tick_go;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [IW-1:0] led_idx;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign tick_go     = in_valid_i & ~busy & frame_tick_i;

  // Write configuration registers, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit <= LIMIT_RESET;
      cfg_q.step  <= STEP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_IDX_LIMIT) begin
        cfg_q.limit <= cfg_data_i[7:0];
      end else if (cfg_index_i == CFG_IDX_STEP) begin
        cfg_q.step <= cfg_data_i[3:0];
      end
    end
  end

  lrrf_ring_ram #(
    .DEPTH (RING_SIZE),
    .AW    (IW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  lrrf_frame_seq #(
    .RING_SIZE    (RING_SIZE),
    .SPREAD_REACH (SPREAD_REACH),
    .IW           (IW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .tick_go_i   (tick_go),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .led_idx_o   (led_idx),
    .last_led_o  (last_led_o)
  );

  assign led_index_o  = 5'(led_idx);
  assign blue_level_o = rd_data;

  // A frame tick starts a frame that blocks further input
  `LRRF_ASSERT_NEXT(a_tick_busy, in_valid_i && !in_stall_o && frame_tick_i, in_stall_o)
  // No LED word goes out while input is open
  `LRRF_ASSERT_NOW(a_out_blocks_in, out_valid_o, in_stall_o)
  // The last LED word ends the frame
  `LRRF_ASSERT_NEXT(a_last_ends, out_valid_o && last_led_o && !out_stall_i,
                    !out_valid_o && !in_stall_o)

endmodule

/* hdl/lrrf_ring_ram.sv */
// Blue level store: one write port, one read port, registered read data.
module lrrf_ring_ram #(
  parameter int unsigned DEPTH = 18,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i
);

  logic [7:0] mem_q [DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read on enable, hold the data otherwise
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

/* hdl/lrrf_frame_seq.sv */
// Frame sequencer: ramp pass, seed search, seeding and readout over the level store.
module lrrf_frame_seq #(
  parameter int unsigned RING_SIZE    = 18,
  parameter int unsigned SPREAD_REACH = 4,
  parameter int unsigned IW           = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrrf_pkg::lrrf_cfg_t cfg_i,
  input  logic                tick_go_i,
  output logic                busy_o,
  output logic                rd_en_o,
  output logic [IW-1:0]       rd_addr_o,
  input  logic [7:0]          rd_data_i,
  output logic                wr_en_o,
  output logic [IW-1:0]       wr_addr_o,
  output logic [7:0]          wr_data_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [IW-1:0]       led_idx_o,
  output logic                last_led_o
);
  import lrrf_pkg::*;

  localparam int unsigned PW = (SPREAD_REACH > 0) ? $clog2(SPREAD_REACH + 1) : 1;
  localparam logic [IW-1:0] LastIdx  = IW'(RING_SIZE - 1);
  localparam logic [IW-1:0] HalfRing = IW'(RING_SIZE / 2);
  localparam logic [IW-1:0] ReachMod = IW'(SPREAD_REACH % RING_SIZE);
  localparam logic [IW-1:0] OneIdx   = IW'(1);
  localparam logic [IW-1:0] TwoIdx   = IW'(2);
  localparam logic [PW-1:0] LastPrb  = PW'(SPREAD_REACH);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RAMP     = 3'd1;
  localparam logic [2:0] S_PRB_RD   = 3'd2;
  localparam logic [2:0] S_PRB_CHK  = 3'd3;
  localparam logic [2:0] S_SEED     = 3'd4;
  localparam logic [2:0] S_OUT_RD   = 3'd5;
  localparam logic [2:0] S_OUT_WAIT = 3'd6;
  localparam logic [2:0] S_CLEAR    = 3'd7;

  // Ring position arithmetic, both operands below RING_SIZE
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IW+1)'(RING_SIZE)) begin
      s = s - (IW+1)'(RING_SIZE);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] wrap_sub(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + (IW+1)'(RING_SIZE) - {1'b0, b};
    end
    return s[IW-1:0];
  endfunction

  // Per-frame ramp of one level
  function automatic logic [7:0] ramp_level(input logic [7:0] b, input logic up,
                                            input logic [7:0] lim, input logic [3:0] stp);
    logic [8:0] sum;
    logic [7:0] r;
    sum = {1'b0, b} + {5'd0, stp};
    if (up) begin
      if (b == 8'd0) begin
        r = 8'd0;
      end else if (b < lim) begin
        r = sum[8] ? 8'hFF : sum[7:0];
      end else begin
        r = lim;
      end
    end else begin
      if (b >= lim) begin
        r = lim;
      end else if (b == 8'd0) begin
        r = 8'd0;
      end else begin
        r = (b > {4'd0, stp}) ? b - {4'd0, stp} : 8'd0;
      end
    end
    return r;
  endfunction

  logic [2:0]    state_q, state_d;
  logic          rising_q, rising_d;
  logic [IW-1:0] origin_q, origin_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          rd_end_q, rd_end_d;
  logic          wr_vld_q, wr_vld_d;
  logic [IW-1:0] wr_idx_q, wr_idx_d;
  logic [IW-1:0] pos_q, pos_d;
  logic [IW-1:0] posn_q, posn_d;
  logic [PW-1:0] prb_cnt_q, prb_cnt_d;
  logic [1:0]    seed_cnt_q, seed_cnt_d;
  logic          done_q, done_d;
  logic [7:0]    seed_lvl_q, seed_lvl_d;

  logic       prb_hit;
  logic       lvl_done;
  logic       done_all;
  logic [7:0] lim_less_step;

  assign lim_less_step = (cfg_i.limit > {4'd0, cfg_i.step}) ?
                         cfg_i.limit - {4'd0, cfg_i.step} : 8'd0;
  assign prb_hit  = rising_q ? (rd_data_i == 8'd0) : (rd_data_i == cfg_i.limit);
  assign lvl_done = rising_q ? (rd_data_i >= cfg_i.limit) : (rd_data_i == 8'd0);
  assign done_all = done_q & lvl_done;

  // Sequence one frame through the store
  always_comb begin
    state_d    = state_q;
    rising_d   = rising_q;
    origin_d   = origin_q;
    idx_d      = idx_q;
    rd_end_d   = rd_end_q;
    wr_vld_d   = wr_vld_q;
    wr_idx_d   = wr_idx_q;
    pos_d      = pos_q;
    posn_d     = posn_q;
    prb_cnt_d  = prb_cnt_q;
    seed_cnt_d = seed_cnt_q;
    done_d     = done_q;
    seed_lvl_d = seed_lvl_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = idx_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = wr_idx_q;
    wr_data_o  = ramp_level(rd_data_i, rising_q, cfg_i.limit, cfg_i.step);
    case (state_q)
      S_CLEAR: begin
        // zero one entry per cycle after reset
        wr_en_o   = 1'b1;
        wr_addr_o = idx_q;
        wr_data_o = 8'd0;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + OneIdx;
        end
      end
      S_IDLE: begin
        if (tick_go_i) begin
          state_d  = S_RAMP;
          idx_d    = '0;
          rd_end_d = 1'b0;
          wr_vld_d = 1'b0;
          done_d   = 1'b1;
        end
      end
      S_RAMP: begin
        // issue reads ahead, write the ramped word back in the following cycle
        if (!rd_end_q) begin
          rd_en_o  = 1'b1;
          wr_vld_d = 1'b1;
          wr_idx_d = idx_q;
          if (idx_q == LastIdx) begin
            rd_end_d = 1'b1;
          end else begin
            idx_d = idx_q + OneIdx;
          end
        end else begin
          wr_vld_d = 1'b0;
        end
        if (wr_vld_q) begin
          wr_en_o = 1'b1;
          if (wr_idx_q == LastIdx) begin
            state_d   = S_PRB_RD;
            wr_vld_d  = 1'b0;
            prb_cnt_d = '0;
            if (rising_q) begin
              pos_d  = origin_q;
              posn_d = origin_q;
            end else begin
              pos_d  = wrap_add(origin_q, ReachMod);
              posn_d = wrap_sub(origin_q, ReachMod);
            end
          end
        end
      end
      S_PRB_RD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = pos_q;
        state_d   = S_PRB_CHK;
      end
      S_PRB_CHK: begin
        if (prb_hit) begin
          seed_lvl_d = rising_q ? {4'd0, cfg_i.step} : lim_less_step;
          seed_cnt_d = '0;
          state_d    = S_SEED;
        end else if (prb_cnt_q == LastPrb) begin
          idx_d   = '0;
          state_d = S_OUT_RD;
        end else begin
          prb_cnt_d = prb_cnt_q + PW'(1);
          state_d   = S_PRB_RD;
          if (rising_q) begin
            pos_d  = wrap_add(pos_q, OneIdx);
            posn_d = wrap_sub(posn_q, OneIdx);
          end else begin
            pos_d  = wrap_sub(pos_q, OneIdx);
            posn_d = wrap_add(posn_q, OneIdx);
          end
        end
      end
      S_SEED: begin
        // write the hit, its mirror and both opposite LEDs
        wr_en_o   = 1'b1;
        wr_data_o = seed_lvl_q;
        case (seed_cnt_q)
          2'd0:    wr_addr_o = pos_q;
          2'd1:    wr_addr_o = wrap_add(pos_q, HalfRing);
          2'd2:    wr_addr_o = posn_q;
          default: wr_addr_o = wrap_add(posn_q, HalfRing);
        endcase
        if (seed_cnt_q == 2'd3) begin
          idx_d   = '0;
          state_d = S_OUT_RD;
        end else begin
          seed_cnt_d = seed_cnt_q + 2'd1;
        end
      end
      S_OUT_RD: begin
        rd_en_o = 1'b1;
        state_d = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        // read data holds in the store's output register until taken
        if (!out_stall_i) begin
          done_d = done_all;
          if (idx_q == LastIdx) begin
            state_d = S_IDLE;
            if (done_all) begin
              rising_d = !rising_q;
              if (!rising_q) begin
                origin_d = wrap_add(origin_q, TwoIdx);
              end
            end
          end else begin
            idx_d   = idx_q + OneIdx;
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      rising_q   <= 1'b1;
      origin_q   <= '0;
      idx_q      <= '0;
      rd_end_q   <= 1'b0;
      wr_vld_q   <= 1'b0;
      wr_idx_q   <= '0;
      pos_q      <= '0;
      posn_q     <= '0;
      prb_cnt_q  <= '0;
      seed_cnt_q <= '0;
      done_q     <= 1'b1;
    end else begin
      state_q    <= state_d;
      rising_q   <= rising_d;
      origin_q   <= origin_d;
      idx_q      <= idx_d;
      rd_end_q   <= rd_end_d;
      wr_vld_q   <= wr_vld_d;
      wr_idx_q   <= wr_idx_d;
      pos_q      <= pos_d;
      posn_q     <= posn_d;
      prb_cnt_q  <= prb_cnt_d;
      seed_cnt_q <= seed_cnt_d;
      done_q     <= done_d;
    end
  end

  // Hold the seed level
  always_ff @(posedge clk_i) begin
    seed_lvl_q <= seed_lvl_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT_WAIT);
  assign led_idx_o   = idx_q;
  assign last_led_o  = (idx_q == LastIdx);

endmodule

/* sim/tb_led_ring_ripple_fader_core.sv */
// Self-checking testbench for the LED ring ripple fader core.
module tb_led_ring_ripple_fader_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lrrf_pkg::*;

  localparam int unsigned LEDS = 18;
  localparam int unsigned REACH = 4;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER_WORDS = 3000;
  localparam int unsigned NUM_PLAN = 24;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned MAX_PRINTS = 40;

  // Register indexes outside the list, which the block ignores
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_LO = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_HI = 4'hF;

  typedef struct packed {
    logic [4:0] idx;
    logic [7:0] lvl;
    logic       last;
  } led_word_t;

  // One row of the directed sequence: a register write or a frame word
  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [7:0]         data;
    logic               tick;
    logic               typed;
    logic [7:0]         led0;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                frame_tick_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [4:0]          led_index_o;
  logic [7:0]          blue_level_o;
  logic                last_led_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predictor state
  logic [7:0]  ring_lvl [LEDS];
  bit          going_up;
  int unsigned origin;
  logic [7:0]  cfg_limit;
  logic [3:0]  cfg_step;

  led_word_t   ring_words_q [$];
  plan_row_t   plan [NUM_PLAN];
  int          err_count = 0;
  int          seen_words = 0;
  int          idle_cycles = 0;
  bit          calm;
  bit          hold_done = 1'b0;
  led_word_t   got_w;
  led_word_t   want_w;

  led_ring_ripple_fader_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_tick_i (frame_tick_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .led_index_o  (led_index_o),
    .blue_level_o (blue_level_o),
    .last_led_o   (last_led_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    end
  endtask

  // Advance the ring by one frame and queue the 18 words it reports
  function automatic void fade_frame();
    int b, i, k, off, pos, posn, lim, stp, seed;
    bit found, done;
    led_word_t w;
    lim = cfg_limit;
    stp = cfg_step;
    // Ramp every lit LED toward its goal
    for (i = 0; i < LEDS; i++) begin
      b = ring_lvl[i];
      if (going_up) begin
        if (b > 0) begin
          if (b < lim) begin
            b = b + stp;
            if (b > 255) b = 255;
          end else begin
            b = lim;
          end
        end
      end else begin
        if (b >= lim) b = lim;
        else if (b > 0) b = (b > stp) ? b - stp : 0;
      end
      ring_lvl[i] = 8'(b);
    end
    // Probe around the origin (outward when rising, inward when falling) and seed four mirrored LEDs on a hit
    found = 1'b0;
    seed = going_up ? stp : ((lim > stp) ? lim - stp : 0);
    for (k = 0; k <= REACH; k++) begin
      off = going_up ? k : REACH - k;
      pos = (origin + off) % LEDS;
      posn = (origin + LEDS - (off % LEDS)) % LEDS;
      if (!found && ((going_up && ring_lvl[pos] == 0) ||
                     (!going_up && ring_lvl[pos] == lim))) begin
        found = 1'b1;
        ring_lvl[pos] = 8'(seed);
        ring_lvl[(pos + LEDS / 2) % LEDS] = 8'(seed);
        ring_lvl[posn] = 8'(seed);
        ring_lvl[(posn + LEDS / 2) % LEDS] = 8'(seed);
      end
    end
    // Flip direction once every LED has reached its goal
    done = 1'b1;
    for (i = 0; i < LEDS; i++) begin
      if (going_up && ring_lvl[i] < lim) done = 1'b0;
      if (!going_up && ring_lvl[i] > 0) done = 1'b0;
    end
    if (done) begin
      going_up = !going_up;
      if (going_up) origin = (origin + 2) % LEDS;
    end
    for (i = 0; i < LEDS; i++) begin
      w.idx = 5'(i);
      w.lvl = ring_lvl[i];
      w.last = (i == LEDS - 1);
      ring_words_q.push_back(w);
    end
  endfunction

  // Offer one frame word, idling first at random; return at the accepting edge
  task automatic send_frame(input logic tick);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_tick_i <= tick;
    do @(posedge clk_i); while (in_stall_o);
    if (tick) fade_frame();
  endtask

  // Write one register; valid stays high for a following write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_IDX_LIMIT) cfg_limit = data;
    else if (idx == CFG_IDX_STEP) cfg_step = data[3:0];
  endtask

  // Stop offering words and let the block run dry
  task automatic drain();
    in_valid_i <= 1'b0;
    while (ring_words_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Compare each accepted LED word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_words++;
      got_w = '{idx: led_index_o, lvl: blue_level_o, last: last_led_o};
      if (ring_words_q.size() == 0) begin
        report_mismatch("unexpected word, led_index", got_w.idx, -1);
      end else begin
        want_w = ring_words_q.pop_front();
        if (got_w.idx !== want_w.idx) report_mismatch("led_index", got_w.idx, want_w.idx);
        if (got_w.lvl !== want_w.lvl) report_mismatch("blue_level", got_w.lvl, want_w.lvl);
        if (got_w.last !== want_w.last) report_mismatch("last_led", got_w.last, want_w.last);
      end
    end
  end

  // Stall the output at random, and hold it off once for a long stretch
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!hold_done && seen_words >= HOLD_AFTER_WORDS) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 14);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
        $display("tb_led_ring_ripple_fader_core: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int r, ph, n;
    bit cfg_open;
    logic tick;
    led_word_t w;
    plan_row_t row;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    frame_tick_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    calm = 1'b0;
    cfg_open = 1'b0;
    for (r = 0; r < LEDS; r++) ring_lvl[r] = '0;
    going_up = 1'b1;
    origin = 0;
    cfg_limit = LIMIT_RESET;
    cfg_step = STEP_RESET;

    // Directed rows: reset defaults, register extremes, masked step bits,
    // ignored indexes, zero step, zero limit, and words without a tick
    plan = '{
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b1, 8'd3},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b0, 1'b0, 8'd0},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b1, 8'd6},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b1, 8'd9},
      '{1'b1, CFG_IDX_STEP,     8'hFF, 1'b0, 1'b0, 8'd0},
      '{1'b1, CFG_IDX_LIMIT,    8'hFF, 1'b0, 1'b0, 8'd0},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b0, 8'd0},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b0, 8'd0},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b0, 8'd0},
      '{1'b1, CFG_IDX_SPARE_LO, 8'hAA, 1'b0, 1'b0, 8'd0},
      '{1'b1, CFG_IDX_SPARE_HI, 8'h55, 1'b0, 1'b0, 8'd0},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b0, 8'd0},
      '{1'b1, CFG_IDX_STEP,     8'h00, 1'b0, 1'b0, 8'd0},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b0, 8'd0},
      '{1'b1, CFG_IDX_LIMIT,    8'h00, 1'b0, 1'b0, 8'd0},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b0, 8'd0},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b0, 8'd0},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b0, 8'd0},
      '{1'b1, CFG_IDX_STEP,     8'h01, 1'b0, 1'b0, 8'd0},
      '{1'b1, CFG_IDX_LIMIT,    8'd3,  1'b0, 1'b0, 8'd0},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b0, 8'd0},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b0, 8'd0},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b0, 1'b0, 8'd0},
      '{1'b0, CFG_IDX_LIMIT,    8'h00, 1'b1, 1'b0, 8'd0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows; typed rows pin the level of LED 0
    for (r = 0; r < NUM_PLAN; r++) begin
      row = plan[r];
      if (row.is_cfg) begin
        if (!cfg_open) begin
          drain();
          cfg_open = 1'b1;
        end
        write_reg(row.idx, row.data);
      end else begin
        if (cfg_open) begin
          cfg_valid_i <= 1'b0;
          cfg_open = 1'b0;
        end
        send_frame(row.tick);
        if (row.typed) begin
          n = ring_words_q.size() - LEDS;
          w = ring_words_q[n];
          w.lvl = row.led0;
          ring_words_q[n] = w;
        end
      end
    end
    if (cfg_open) cfg_valid_i <= 1'b0;

    // Random phases, each under its own fade settings
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      calm = (ph == 0);
      case (ph)
        0: begin write_reg(CFG_IDX_LIMIT, 8'd20); write_reg(CFG_IDX_STEP, 8'd7); end
        1: begin write_reg(CFG_IDX_LIMIT, 8'd3); write_reg(CFG_IDX_STEP, 8'd1); end
        2: begin write_reg(CFG_IDX_LIMIT, 8'd240); write_reg(CFG_IDX_STEP, 8'd15); end
        3: begin write_reg(CFG_IDX_LIMIT, 8'd45); write_reg(CFG_IDX_STEP, 8'd4); end
        4: begin
          write_reg(CFG_IDX_LIMIT, 8'($urandom_range(240, 3)));
          write_reg(CFG_IDX_STEP, 8'($urandom_range(15, 1)));
        end
        default: begin
          write_reg(CFG_IDX_LIMIT, 8'($urandom_range(255)));
          write_reg(CFG_IDX_STEP, 8'($urandom_range(255)));
        end
      endcase
      if ($urandom_range(1) == 1) begin
        write_reg(4'($urandom_range(15, 2)), 8'($urandom_range(255)));
      end
      cfg_valid_i <= 1'b0;
      n = 0;
      while (n < 74) begin
        tick = ($urandom_range(9) != 0);
        send_frame(tick);
        n++;
      end
    end
    calm = 1'b0;

    drain();
    if (err_count == 0) begin
      $display("tb_led_ring_ripple_fader_core: done, clean");
    end else begin
      $display("tb_led_ring_ripple_fader_core: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/lrrf_pkg.sv
hdl/lrrf_ring_ram.sv
hdl/lrrf_frame_seq.sv
hdl/led_ring_ripple_fader_core.sv
sim/tb_led_ring_ripple_fader_core.sv
